// ===== hdl/line_segment_extend_measure_defines.svh =====
// Assertion macros used by the checker file.
`ifndef LINE_SEGMENT_EXTEND_MEASURE_DEFINES_SVH
`define LINE_SEGMENT_EXTEND_MEASURE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LSEM_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lsem assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LSEM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lsem assertion failed");

`endif

// ===== hdl/lsem_pkg.sv =====
`default_nettype none

package lsem_pkg;

  localparam int CW       = 12;
  localparam int ROW_W    = 12;
  localparam int PW       = 28;
  localparam int YW       = 13;
  localparam int PROD_W   = YW + PW;
  localparam int NW       = 36;
  localparam int DW       = 25;
  localparam int FRAC     = 16;
  localparam int LEN_W    = 16;
  localparam int SQ_W     = 2 * LEN_W;
  localparam int SQ_RW    = LEN_W + 3;
  localparam int SQ_STEPS = LEN_W;
  localparam int DXS_W    = DW;

  localparam logic [ROW_W-1:0] ROW_RESET = ROW_W'(480);

  typedef logic signed [PW-1:0] pos_t;
  typedef logic signed [NW:0] quo_t;

  localparam pos_t TWO     = pos_t'(2);
  localparam pos_t S16_MAX = pos_t'(32767);
  localparam pos_t S16_MIN = pos_t'(-32768);
  localparam quo_t Q_MAX   = quo_t'(2147483647);
  localparam quo_t Q_MIN   = -quo_t'(2147483647) - quo_t'(1);

  typedef enum logic [0:0] {
    REG_ROW_COUNT     = 1'b0,
    REG_EXTEND_ENABLE = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    pos_t             x0;
    pos_t             y0;
    pos_t             x1;
    pos_t             y1;
    pos_t             dx;
    pos_t             dy;
    logic [ROW_W-1:0] t;
    logic             en;
    logic             mv;
    logic [LEN_W-1:0] len;
    logic             undef;
  } seg_t;

  typedef struct packed {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] ex;
    logic signed [15:0] ey;
    logic [LEN_W-1:0]   len;
    logic signed [31:0] slope;
    logic               undef;
  } res_t;

  function automatic logic abs_gt2(pos_t v);
    return (v > TWO) || (v < -TWO);
  endfunction

  function automatic logic abs_lt2(pos_t v);
    return (v < TWO) && (v > -TWO);
  endfunction

  function automatic logic [15:0] sat16(pos_t v);
    logic [15:0] r;
    if (v > S16_MAX) begin
      r = 16'h7FFF;
    end else if (v < S16_MIN) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] sat32(quo_t v);
    logic [31:0] r;
    if (v > Q_MAX) begin
      r = 32'h7FFF_FFFF;
    end else if (v < Q_MIN) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/lsem_if.sv =====
`default_nettype none

interface seg_in_if;
  logic                     valid;
  logic                     ready;
  logic [lsem_pkg::CW-1:0] start_x;
  logic [lsem_pkg::CW-1:0] start_y;
  logic [lsem_pkg::CW-1:0] end_x;
  logic [lsem_pkg::CW-1:0] end_y;
  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface res_if;
  logic                        valid;
  logic                        ready;
  logic signed [15:0]          out_start_x;
  logic signed [15:0]          out_start_y;
  logic signed [15:0]          out_end_x;
  logic signed [15:0]          out_end_y;
  logic [lsem_pkg::LEN_W-1:0] seg_length;
  logic signed [31:0]          slope_q16;
  logic                        slope_undefined;
  modport source (output valid, out_start_x, out_start_y, out_end_x, out_end_y,
                  seg_length, slope_q16, slope_undefined, input ready);
  modport sink (input valid, out_start_x, out_start_y, out_end_x, out_end_y,
                seg_length, slope_q16, slope_undefined, output ready);
endinterface

interface cfg_if;
  logic                        valid;
  logic                        ready;
  lsem_pkg::cfg_reg_e          index;
  logic [lsem_pkg::ROW_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/lsem_div.sv =====
`default_nettype none

module lsem_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic signed [lsem_pkg::NW:0] num_i,
  input  logic signed [lsem_pkg::DW:0] den_i,
  input  lsem_pkg::seg_t        side_i,
  output logic                  valid_o,
  output lsem_pkg::quo_t        quo_o,
  output lsem_pkg::seg_t        side_o
);

  localparam int NW = lsem_pkg::NW;
  localparam int DW = lsem_pkg::DW;
  localparam int ZW = DW + 1 + NW;

  logic [ZW-1:0]   z_q   [0:NW];
  logic [DW-1:0]   d_q   [0:NW];
  logic            neg_q [0:NW];
  logic            vld_q [0:NW];
  lsem_pkg::seg_t  s_q   [0:NW];

  logic [NW:0]   num_abs;
  logic [DW:0]   den_abs;
  logic [NW-1:0] mag;

  assign num_abs = num_i[NW] ? (NW + 1)'(0) - num_i : num_i;
  assign den_abs = den_i[DW] ? (DW + 1)'(0) - den_i : den_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_q[0]   <= {(DW + 1)'(0), num_abs[NW-1:0]};
      d_q[0]   <= den_abs[DW-1:0];
      neg_q[0] <= num_i[NW] ^ den_i[DW];
      s_q[0]   <= side_i;
    end
  end

  for (genvar i = 0; i < NW; i++) begin : g_step
    logic [ZW-1:0] zs;
    logic [DW:0]   hi;
    logic          ge;
    logic [ZW-1:0] zn;

    always_comb begin
      zs = {z_q[i][ZW-2:0], 1'b0};
      hi = zs[ZW-1:NW];
      ge = hi >= {1'b0, d_q[i]};
      zn = ge ? {hi - {1'b0, d_q[i]}, zs[NW-1:1], 1'b1} : zs;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        z_q[i+1]   <= zn;
        d_q[i+1]   <= d_q[i];
        neg_q[i+1] <= neg_q[i];
        s_q[i+1]   <= s_q[i];
      end
    end
  end

  assign mag     = z_q[NW][NW-1:0];
  assign quo_o   = neg_q[NW] ? (NW + 1)'(0) - {1'b0, mag} : {1'b0, mag};
  assign valid_o = vld_q[NW];
  assign side_o  = s_q[NW];

endmodule

`default_nettype wire

// ===== hdl/line_segment_extend_measure.sv =====
// Throughput: one segment per cycle while the skid stage is empty; three 37-stage
// dividers and a 17-stage square root unit form the pipeline, and a skid stage
// absorbs output stalls; while it holds a result, the whole pipeline stalls.
// Reset: asynchronous, active low; clears all valid bits and the skid stage,
// and sets row_count to 480 and extend_enable to 1.
`default_nettype none

module line_segment_extend_measure (
  input  logic     clk_i,
  input  logic     rst_ni,
  seg_in_if.sink   seg_i,
  res_if.source    res_o,
  cfg_if.sink      cfg_i
);

  localparam int PW = lsem_pkg::PW;
  localparam int YW = lsem_pkg::YW;
  localparam int NW = lsem_pkg::NW;
  localparam int DW = lsem_pkg::DW;

  logic                        en;
  logic                        accept;
  logic [lsem_pkg::ROW_W-1:0]  row_q;
  logic                        ext_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= lsem_pkg::ROW_RESET;
      ext_q <= 1'b1;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        lsem_pkg::REG_ROW_COUNT:     row_q <= cfg_i.data;
        lsem_pkg::REG_EXTEND_ENABLE: ext_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  logic skid_vld_q;
  assign en          = ~skid_vld_q;
  assign seg_i.ready = en;
  assign accept      = seg_i.valid & en;

  // Stage A: capture the endpoints and, when extension is enabled, order them.
  lsem_pkg::seg_t a_d, a_q;
  logic           a_vld_q;
  logic           swap;

  always_comb begin
    swap     = ext_q && (seg_i.start_y < seg_i.end_y);
    a_d      = '0;
    a_d.x0   = lsem_pkg::pos_t'(swap ? seg_i.end_x : seg_i.start_x);
    a_d.y0   = lsem_pkg::pos_t'(swap ? seg_i.end_y : seg_i.start_y);
    a_d.x1   = lsem_pkg::pos_t'(swap ? seg_i.start_x : seg_i.end_x);
    a_d.y1   = lsem_pkg::pos_t'(swap ? seg_i.start_y : seg_i.end_y);
    a_d.t    = row_q;
    a_d.en   = ext_q;
  end

  // Stage B: first move, product and divisor.
  lsem_pkg::pos_t       b_dx, b_dy, b_ny;
  logic signed [PW+YW-1:0] b_prod;
  lsem_pkg::seg_t       b_d, b_q;
  logic signed [NW:0]   b_num_q;
  logic signed [DW:0]   b_den_q;
  logic                 b_vld_q;

  always_comb begin
    b_dx   = a_q.x1 - a_q.x0;
    b_dy   = a_q.y0 - a_q.y1;
    b_ny   = lsem_pkg::pos_t'(a_q.t) - a_q.y0;
    b_prod = $signed(b_ny[YW-1:0]) * b_dx;
    b_d    = a_q;
    b_d.mv = a_q.en && lsem_pkg::abs_gt2(b_dy) && !lsem_pkg::abs_lt2(b_ny);
  end

  logic           d1_vld;
  lsem_pkg::quo_t d1_quo;
  lsem_pkg::seg_t d1_s;

  lsem_div u_div_first (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (b_vld_q),
    .num_i   (b_num_q),
    .den_i   (b_den_q),
    .side_i  (b_q),
    .valid_o (d1_vld),
    .quo_o   (d1_quo),
    .side_o  (d1_s)
  );

  // Stage C: apply the first move.
  lsem_pkg::seg_t c_d, c_q;
  logic           c_vld_q;

  always_comb begin
    c_d = d1_s;
    if (d1_s.mv) begin
      c_d.x0 = d1_s.x0 - lsem_pkg::pos_t'(d1_quo);
      c_d.y0 = lsem_pkg::pos_t'(d1_s.t);
    end
  end

  // Stage D: second move, product and divisor.
  lsem_pkg::pos_t       d_dx, d_dy, d_ny, d_t2;
  logic signed [PW+YW-1:0] d_prod;
  lsem_pkg::seg_t       d_d, d_q;
  logic signed [NW:0]   d_num_q;
  logic signed [DW:0]   d_den_q;
  logic                 d_vld_q;

  always_comb begin
    d_dx   = c_q.x1 - c_q.x0;
    d_dy   = c_q.y0 - c_q.y1;
    d_t2   = lsem_pkg::pos_t'(c_q.t >> 1);
    d_ny   = d_t2 - c_q.y1;
    d_prod = $signed(d_ny[YW-1:0]) * d_dx;
    d_d    = c_q;
    d_d.mv = c_q.en && lsem_pkg::abs_gt2(d_dy) && !lsem_pkg::abs_lt2(d_ny);
  end

  logic           d2_vld;
  lsem_pkg::quo_t d2_quo;
  lsem_pkg::seg_t d2_s;

  lsem_div u_div_second (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_vld_q),
    .num_i   (d_num_q),
    .den_i   (d_den_q),
    .side_i  (d_q),
    .valid_o (d2_vld),
    .quo_o   (d2_quo),
    .side_o  (d2_s)
  );

  // Stage E: apply the second move.
  lsem_pkg::seg_t e_d, e_q;
  logic           e_vld_q;

  always_comb begin
    e_d = d2_s;
    if (d2_s.mv) begin
      e_d.x1 = d2_s.x1 - lsem_pkg::pos_t'(d2_quo);
      e_d.y1 = lsem_pkg::pos_t'(d2_s.t >> 1);
    end
  end

  // Stage F: final spans and their squares.
  lsem_pkg::seg_t        f_d, f_q;
  logic signed [2*DW-1:0] f_dx2, f_dx2_q;
  logic signed [2*YW-1:0] f_dy2, f_dy2_q;
  logic                  f_vld_q;

  always_comb begin
    f_d    = e_q;
    f_d.dx = e_q.x1 - e_q.x0;
    f_d.dy = e_q.y0 - e_q.y1;
    f_dx2  = $signed(f_d.dx[DW-1:0]) * $signed(f_d.dx[DW-1:0]);
    f_dy2  = $signed(f_d.dy[YW-1:0]) * $signed(f_d.dy[YW-1:0]);
  end

  // Stage G and the square root steps.
  localparam int SQ_W  = lsem_pkg::SQ_W;
  localparam int SQ_RW = lsem_pkg::SQ_RW;
  localparam int SQ_N  = lsem_pkg::SQ_STEPS;
  localparam int LEN_W = lsem_pkg::LEN_W;

  logic [2*DW:0]      g_sum;
  logic [SQ_W-1:0]    sq_v_q    [0:SQ_N];
  logic [SQ_RW-1:0]   sq_r_q    [0:SQ_N];
  logic [LEN_W-1:0]   sq_root_q [0:SQ_N];
  logic               sq_sat_q  [0:SQ_N];
  logic               sq_vld_q  [0:SQ_N];
  lsem_pkg::seg_t     sq_s_q    [0:SQ_N];

  assign g_sum = (2 * DW + 1)'($unsigned(f_dx2_q)) + (2 * DW + 1)'($unsigned(f_dy2_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q[0] <= 1'b0;
    end else if (en) begin
      sq_vld_q[0] <= f_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_v_q[0]    <= g_sum[SQ_W-1:0];
      sq_r_q[0]    <= '0;
      sq_root_q[0] <= '0;
      sq_sat_q[0]  <= |g_sum[2*DW:SQ_W];
      sq_s_q[0]    <= f_q;
    end
  end

  for (genvar i = 0; i < SQ_N; i++) begin : g_sqrt
    logic [SQ_RW-1:0] r4;
    logic [SQ_RW-1:0] trial;
    logic             ge;

    always_comb begin
      r4    = {sq_r_q[i][SQ_RW-3:0], sq_v_q[i][SQ_W-1 -: 2]};
      trial = SQ_RW'({sq_root_q[i], 2'b01});
      ge    = r4 >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[i+1] <= 1'b0;
      end else if (en) begin
        sq_vld_q[i+1] <= sq_vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_v_q[i+1]    <= {sq_v_q[i][SQ_W-3:0], 2'b00};
        sq_r_q[i+1]    <= ge ? r4 - trial : r4;
        sq_root_q[i+1] <= {sq_root_q[i][LEN_W-2:0], ge};
        sq_sat_q[i+1]  <= sq_sat_q[i];
        sq_s_q[i+1]    <= sq_s_q[i];
      end
    end
  end

  // Stage H: length, slope operands.
  lsem_pkg::seg_t     h_d, h_q;
  logic signed [NW:0] h_num_q;
  logic signed [DW:0] h_den_q;
  logic               h_vld_q;

  always_comb begin
    h_d       = sq_s_q[SQ_N];
    h_d.len   = sq_sat_q[SQ_N] ? '1 : sq_root_q[SQ_N];
    h_d.undef = lsem_pkg::abs_lt2(h_d.dx);
  end

  logic           d3_vld;
  lsem_pkg::quo_t d3_quo;
  lsem_pkg::seg_t d3_s;

  lsem_div u_div_slope (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (h_vld_q),
    .num_i   (h_num_q),
    .den_i   (h_den_q),
    .side_i  (h_q),
    .valid_o (d3_vld),
    .quo_o   (d3_quo),
    .side_o  (d3_s)
  );

  // Pipeline registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
      f_vld_q <= 1'b0;
      h_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= accept;
      b_vld_q <= a_vld_q;
      c_vld_q <= d1_vld;
      d_vld_q <= c_vld_q;
      e_vld_q <= d2_vld;
      f_vld_q <= e_vld_q;
      h_vld_q <= sq_vld_q[SQ_N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q     <= a_d;
      b_q     <= b_d;
      b_num_q <= b_prod[NW:0];
      b_den_q <= b_dy[DW:0];
      c_q     <= c_d;
      d_q     <= d_d;
      d_num_q <= d_prod[NW:0];
      d_den_q <= d_dy[DW:0];
      e_q     <= e_d;
      f_q     <= f_d;
      f_dx2_q <= f_dx2;
      f_dy2_q <= f_dy2;
      h_q     <= h_d;
      h_num_q <= {h_d.dy[NW-lsem_pkg::FRAC:0], lsem_pkg::FRAC'(0)};
      h_den_q <= h_d.dx[DW:0];
    end
  end

  // Result formatting, output register and skid stage.
  lsem_pkg::res_t res_d, out_q, skid_q;
  logic           out_vld_q;
  logic           take;

  always_comb begin
    res_d.sx    = lsem_pkg::sat16(d3_s.x0);
    res_d.sy    = lsem_pkg::sat16(d3_s.y0);
    res_d.ex    = lsem_pkg::sat16(d3_s.x1);
    res_d.ey    = lsem_pkg::sat16(d3_s.y1);
    res_d.len   = d3_s.len;
    res_d.slope = d3_s.undef ? 32'sd0 : lsem_pkg::sat32(d3_quo);
    res_d.undef = d3_s.undef;
  end

  assign take = out_vld_q & res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (take) begin
        skid_vld_q <= 1'b0;
      end
    end else if (d3_vld) begin
      if (out_vld_q && !take) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (take) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (d3_vld) begin
      if (out_vld_q && !take) begin
        skid_q <= res_d;
      end else begin
        out_q <= res_d;
      end
    end
  end

  assign res_o.valid           = out_vld_q;
  assign res_o.out_start_x     = out_q.sx;
  assign res_o.out_start_y     = out_q.sy;
  assign res_o.out_end_x       = out_q.ex;
  assign res_o.out_end_y       = out_q.ey;
  assign res_o.seg_length      = out_q.len;
  assign res_o.slope_q16       = out_q.slope;
  assign res_o.slope_undefined = out_q.undef;

endmodule

`default_nettype wire

// ===== hdl/lsem_checker.sv =====
`default_nettype none
`include "line_segment_extend_measure_defines.svh"

module lsem_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] slope_q16_i,
  input logic        slope_undefined_i
);

  `LSEM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `LSEM_ASSERT_IMPL(a_undef_zero, clk_i, rst_ni, out_valid_i && slope_undefined_i, slope_q16_i == 32'd0)
  `LSEM_ASSERT_IMPL(a_stall_full, clk_i, rst_ni, !in_ready_i, out_valid_i)

endmodule

bind line_segment_extend_measure lsem_checker u_lsem_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_ready_i        (seg_i.ready),
  .out_valid_i       (res_o.valid),
  .out_ready_i       (res_o.ready),
  .slope_q16_i       (res_o.slope_q16),
  .slope_undefined_i (res_o.slope_undefined)
);

`default_nettype wire

// ===== bench/tb_line_segment_extend_measure.sv =====
`timescale 1ns / 100ps

module tb_line_segment_extend_measure;

  localparam int LIMIT_CYCLES = 600000;
  localparam int DRAIN_CYCLES = 160;
  localparam int RANDOM_ITEMS = 1700;

  typedef struct {
    logic [11:0]    sx;
    logic [11:0]    sy;
    logic [11:0]    ex;
    logic [11:0]    ey;
    bit             typed;
    lsem_pkg::res_t r;
  } seg_row_t;

  logic clk_i;
  logic rst_ni;

  seg_in_if seg();
  res_if    res();
  cfg_if    cfg();

  line_segment_extend_measure u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .seg_i  (seg),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  logic [11:0]    row_count_q;
  bit             extend_q;
  lsem_pkg::res_t pending_results[$];
  int             error_count;
  int             cycle_count;
  bit             burst_mode;
  seg_row_t       dir_rows[$];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic longint abs_l(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic longint root_floor(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic lsem_pkg::res_t predict_segment(logic [11:0] sx, logic [11:0] sy,
                                                     logic [11:0] ex, logic [11:0] ey);
    longint x0, y0, x1, y1, dx, dy, t, p, ny, nx, len, slope, tmp;
    lsem_pkg::res_t r;
    x0 = longint'(sx);
    y0 = longint'(sy);
    x1 = longint'(ex);
    y1 = longint'(ey);
    if (extend_q) begin
      if (y0 < y1) begin
        tmp = x0; x0 = x1; x1 = tmp;
        tmp = y0; y0 = y1; y1 = tmp;
      end
      for (int k = 0; k < 2; k++) begin
        t = (k == 0) ? longint'(row_count_q) : longint'(row_count_q >> 1);
        p = (k == 0) ? y0 : y1;
        dx = x1 - x0;
        dy = y0 - y1;
        if (abs_l(dy) > 2 && abs_l(p - t) >= 2) begin
          ny = t - p;
          nx = (-(ny * dx)) / dy;
          if (k == 0) begin
            x0 = x0 + nx;
            y0 = y0 + ny;
          end else begin
            x1 = x1 + nx;
            y1 = y1 + ny;
          end
        end
      end
    end
    dx = x1 - x0;
    dy = y0 - y1;
    len = root_floor(longint'(dx * dx + dy * dy));
    if (len > 65535) len = 65535;
    slope = 0;
    r.undef = abs_l(dx) < 2;
    if (!r.undef) begin
      slope = (dy * 65536) / dx;
      if (slope > 64'sd2147483647) slope = 64'sd2147483647;
      if (slope < -64'sd2147483648) slope = -64'sd2147483648;
    end
    r.sx = clamp16(x0);
    r.sy = clamp16(y0);
    r.ex = clamp16(x1);
    r.ey = clamp16(y1);
    r.len = len[15:0];
    r.slope = slope[31:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    if (burst_mode) return 0;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic send_segment(seg_row_t row);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      seg.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    seg.valid   = 1'b1;
    seg.start_x = row.sx;
    seg.start_y = row.sy;
    seg.end_x   = row.ex;
    seg.end_y   = row.ey;
    @(posedge clk_i);
    while (!seg.ready) @(posedge clk_i);
    if (row.typed) pending_results.push_back(row.r);
    else pending_results.push_back(predict_segment(row.sx, row.sy, row.ex, row.ey));
    @(negedge clk_i);
  endtask

  task automatic write_register(lsem_pkg::cfg_reg_e idx, logic [11:0] value);
    seg.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data  = value;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    if (idx == lsem_pkg::REG_ROW_COUNT) row_count_q = value;
    else extend_q = value[0];
    @(negedge clk_i);
    cfg.valid = 1'b0;
  endtask

  function automatic seg_row_t random_segment();
    seg_row_t row;
    int       roll;
    row.typed = 1'b0;
    row.r = '0;
    row.sx = 12'($urandom_range(4095));
    row.sy = 12'($urandom_range(4095));
    row.ex = 12'($urandom_range(4095));
    row.ey = 12'($urandom_range(4095));
    roll = $urandom_range(99);
    if (roll < 15) begin
      row.ey = 12'(int'(row.sy) + $urandom_range(4) - 2);
    end else if (roll < 30) begin
      row.ex = 12'(int'(row.sx) + $urandom_range(2) - 1);
    end else if (roll < 40) begin
      row.sy = 12'(int'(row_count_q) + $urandom_range(4) - 2);
    end else if (roll < 50) begin
      row.sx = 12'($urandom_range(64));
      row.ex = 12'($urandom_range(64));
    end
    return row;
  endfunction

  always @(posedge clk_i) begin
    lsem_pkg::res_t want;
    if (rst_ni && res.valid && res.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transaction", $time);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (res.out_start_x !== want.sx) begin
          $display("%0t: out_start_x exp %0d got %0d", $time, want.sx, res.out_start_x);
          error_count++;
        end
        if (res.out_start_y !== want.sy) begin
          $display("%0t: out_start_y exp %0d got %0d", $time, want.sy, res.out_start_y);
          error_count++;
        end
        if (res.out_end_x !== want.ex) begin
          $display("%0t: out_end_x exp %0d got %0d", $time, want.ex, res.out_end_x);
          error_count++;
        end
        if (res.out_end_y !== want.ey) begin
          $display("%0t: out_end_y exp %0d got %0d", $time, want.ey, res.out_end_y);
          error_count++;
        end
        if (res.seg_length !== want.len) begin
          $display("%0t: seg_length exp %0d got %0d", $time, want.len, res.seg_length);
          error_count++;
        end
        if (res.slope_q16 !== want.slope) begin
          $display("%0t: slope_q16 exp %0d got %0d", $time, want.slope, res.slope_q16);
          error_count++;
        end
        if (res.slope_undefined !== want.undef) begin
          $display("%0t: slope_undefined exp %0b got %0b", $time, want.undef,
                   res.slope_undefined);
          error_count++;
        end
      end
    end
  end

  initial begin
    int stall;
    res.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        res.ready = 1'b0;
        stall--;
      end else if (!burst_mode && $urandom_range(99) < 25) begin
        res.ready = 1'b0;
        stall = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3);
      end else begin
        res.ready = 1'b1;
      end
    end
  end

  initial begin
    seg_row_t row;
    cycle_count = 0;
    error_count = 0;
    burst_mode  = 1'b0;
    row_count_q = 12'd480;
    extend_q    = 1'b1;
    rst_ni      = 1'b0;
    seg.valid   = 1'b0;
    seg.start_x = '0;
    seg.start_y = '0;
    seg.end_x   = '0;
    seg.end_y   = '0;
    cfg.valid   = 1'b0;
    cfg.index   = lsem_pkg::REG_ROW_COUNT;
    cfg.data    = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    dir_rows.push_back('{12'd0, 12'd0, 12'd0, 12'd0, 1'b1,
                         '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0, 32'sd0, 1'b1}});
    dir_rows.push_back('{12'd0, 12'd0, 12'd4095, 12'd0, 1'b1,
                         '{16'sd0, 16'sd0, 16'sd4095, 16'sd0, 16'd4095, 32'sd0, 1'b0}});
    dir_rows.push_back('{12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1,
                         '{16'sd4095, 16'sd4095, 16'sd4095, 16'sd4095, 16'd0, 32'sd0, 1'b1}});
    dir_rows.push_back('{12'd5, 12'd100, 12'd6, 12'd100, 1'b1,
                         '{16'sd5, 16'sd100, 16'sd6, 16'sd100, 16'd1, 32'sd0, 1'b1}});
    dir_rows.push_back('{12'd0, 12'd4095, 12'd4095, 12'd0, 1'b0, '0});
    dir_rows.push_back('{12'd4095, 12'd0, 12'd0, 12'd4095, 1'b0, '0});
    dir_rows.push_back('{12'd0, 12'd4000, 12'd4095, 12'd3997, 1'b0, '0});
    dir_rows.push_back('{12'd4095, 12'd4000, 12'd0, 12'd3997, 1'b0, '0});
    dir_rows.push_back('{12'd10, 12'd480, 12'd200, 12'd100, 1'b0, '0});
    dir_rows.push_back('{12'd10, 12'd481, 12'd200, 12'd100, 1'b0, '0});
    dir_rows.push_back('{12'd10, 12'd200, 12'd20, 12'd198, 1'b0, '0});
    dir_rows.push_back('{12'd10, 12'd200, 12'd20, 12'd197, 1'b0, '0});
    dir_rows.push_back('{12'd100, 12'd0, 12'd100, 12'd4095, 1'b0, '0});
    dir_rows.push_back('{12'd100, 12'd10, 12'd101, 12'd4000, 1'b0, '0});
    dir_rows.push_back('{12'd100, 12'd10, 12'd99, 12'd4000, 1'b0, '0});
    dir_rows.push_back('{12'd4095, 12'd4095, 12'd0, 12'd0, 1'b0, '0});
    dir_rows.push_back('{12'd2730, 12'd1365, 12'd1365, 12'd2730, 1'b0, '0});
    dir_rows.push_back('{12'd1365, 12'd2730, 12'd2730, 12'd1365, 1'b0, '0});
    dir_rows.push_back('{12'd300, 12'd400, 12'd310, 12'd241, 1'b0, '0});
    foreach (dir_rows[i]) send_segment(dir_rows[i]);

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          write_register(lsem_pkg::REG_ROW_COUNT, 12'd0);
        end
        1: begin
          write_register(lsem_pkg::REG_ROW_COUNT, 12'd4095);
        end
        2: begin
          write_register(lsem_pkg::REG_ROW_COUNT, 12'($urandom_range(4095)));
        end
        3: begin
          write_register(lsem_pkg::REG_EXTEND_ENABLE, 12'd0);
        end
        4: begin
          write_register(lsem_pkg::REG_ROW_COUNT, 12'd1);
          write_register(lsem_pkg::REG_EXTEND_ENABLE, 12'd1);
        end
        5: begin
          write_register(lsem_pkg::REG_ROW_COUNT, 12'd480);
        end
        default: begin
          write_register(lsem_pkg::REG_ROW_COUNT, 12'($urandom_range(4095)));
        end
      endcase
      for (int n = 0; n < RANDOM_ITEMS / 7; n++) begin
        if (n % 80 == 0) burst_mode = ($urandom_range(3) == 0);
        row = random_segment();
        send_segment(row);
      end
      burst_mode = 1'b0;
    end
    seg.valid = 1'b0;

    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
